/* hw/rtl/jli_pkg.sv */
// Package for the joint linear interpolator: sizes, codes, payload and
// controller/datapath interface types. Depends on nothing.
`default_nettype none
package jli_pkg;

   localparam int NUM_LEGS       = 6;
   localparam int JOINTS_PER_LEG = 3;
   localparam int FRACTION_BITS  = 8;

   localparam int CODE_W      = 16;
   localparam int POS_W       = CODE_W + FRACTION_BITS;
   localparam int DUR_W       = 8;
   localparam int DIVW        = POS_W + DUR_W;
   localparam int DIV_CNT_W   = $clog2(DIVW);
   localparam int NUM_ENTRIES = NUM_LEGS * JOINTS_PER_LEG;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int LEG_W       = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
   localparam int JOINT_W     = (JOINTS_PER_LEG > 1) ? $clog2(JOINTS_PER_LEG) : 1;
   localparam int REPLY_LEG_W = 3;

   localparam logic [CODE_W-1:0] REST_CODE = 16'd7500;
   localparam logic [7:0]        CMD_SET   = 8'd1;

   // Request kinds found by the decoder.
   localparam logic [1:0] KIND_IGNORE = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_SET    = 2'd2;
   localparam logic [1:0] KIND_REPLY  = 2'd3;

   typedef struct packed {
      logic        action;
      logic        is_channel_a;
      logic [10:0] frame_id;
      logic [7:0]  command;
      logic        remote_request;
      logic [15:0] code_joint0;
      logic [15:0] code_joint1;
      logic [15:0] code_joint2;
      logic [7:0]  move_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]  reply_leg;
      logic [15:0] pos_joint0;
      logic [15:0] pos_joint1;
      logic [15:0] pos_joint2;
   } rsp_type;

   typedef struct packed {
      logic               load_req;
      logic               tick_load;
      logic               tick_mul;
      logic               div_step;
      logic               tick_wb;
      logic               set_wr;
      logic               rpl_rd;
      logic               rsp_load;
      logic               last_joint;
      logic [LEG_W-1:0]   leg;
      logic [JOINT_W-1:0] joint;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [LEG_W-1:0] leg;
      logic             rsp_busy;
   } status_type;

endpackage
`default_nettype wire

/* hw/rtl/jli_datapath.sv */
// Datapath of the joint linear interpolator: joint state, request latch,
// multiplier, bit-serial divider and reply register. Depends on jli_pkg.
`default_nettype none
module jli_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  jli_pkg::req_type     req_data,
   input  jli_pkg::cmd_type     cmd,
   output jli_pkg::status_type  status,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   output jli_pkg::rsp_type     rsp_data
);
   import jli_pkg::*;

   logic [CODE_W-1:0] target_ff   [NUM_ENTRIES];
   logic [POS_W-1:0]  start_ff    [NUM_ENTRIES];
   logic [POS_W-1:0]  current_ff  [NUM_ENTRIES];
   logic [DUR_W-1:0]  duration_ff [NUM_LEGS];
   logic [DUR_W-1:0]  elapsed_ff  [NUM_LEGS];

   req_type           req_ff;
   logic [POS_W:0]    diff_ff;
   logic [POS_W-1:0]  st_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [DUR_W-1:0]  el_ff;
   logic              neg_ff;
   logic [DIVW-1:0]   quo_ff, quo_in;
   logic [DUR_W-1:0]  rem_ff, rem_in;
   logic [CODE_W-1:0] stage_ff [3];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]   idx;
   logic [CODE_W-1:0]  code_sel;
   logic [POS_W-1:0]   abs_diff;
   logic [DUR_W:0]     rem_t;
   logic               ge;
   logic [POS_W-1:0]   q_mag, q_signed, wb_pos;
   logic [LEG_W+REPLY_LEG_W-1:0] leg_ext;

   // Flat entry index of the selected leg and joint.
   assign idx = IDX_W'(int'(cmd.leg) * JOINTS_PER_LEG + int'(cmd.joint));

   // Request decode for the controller.
   always_comb begin
      status.leg      = req_ff.frame_id[LEG_W-1:0];
      status.rsp_busy = rsp_valid_ff & ~rsp_ready;
      if (!req_ff.action) begin
         status.kind = KIND_TICK;
      end else if (req_ff.is_channel_a && (req_ff.frame_id < 11'(NUM_LEGS)) &&
                   (req_ff.command == CMD_SET)) begin
         status.kind = req_ff.remote_request ? KIND_REPLY : KIND_SET;
      end else begin
         status.kind = KIND_IGNORE;
      end
   end

   // Target code of the joint being written.
   always_comb begin
      case (cmd.joint)
         JOINT_W'(0): code_sel = req_ff.code_joint0;
         JOINT_W'(1): code_sel = req_ff.code_joint1;
         default:     code_sel = req_ff.code_joint2;
      endcase
   end

   // Magnitude of the step, one restoring division step, and write-back value.
   assign abs_diff = diff_ff[POS_W] ? POS_W'(-diff_ff) : diff_ff[POS_W-1:0];
   assign rem_t    = {rem_ff, quo_ff[DIVW-1]};
   assign ge       = rem_t >= {1'b0, dur_ff};
   assign rem_in   = ge ? DUR_W'(rem_t - {1'b0, dur_ff}) : rem_t[DUR_W-1:0];
   assign quo_in   = {quo_ff[DIVW-2:0], ge};
   assign q_mag    = quo_ff[POS_W-1:0];
   assign q_signed = neg_ff ? POS_W'(-q_mag) : q_mag;
   assign wb_pos   = (dur_ff == '0) ? st_ff : POS_W'(st_ff + q_signed);

   // Joint state arrays.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            target_ff[i]  <= REST_CODE;
            start_ff[i]   <= {REST_CODE, {FRACTION_BITS{1'b0}}};
            current_ff[i] <= {REST_CODE, {FRACTION_BITS{1'b0}}};
         end
         for (int l = 0; l < NUM_LEGS; l++) begin
            duration_ff[l] <= '0;
            elapsed_ff[l]  <= '0;
         end
      end else begin
         if (cmd.set_wr) begin
            target_ff[idx] <= code_sel;
            start_ff[idx]  <= current_ff[idx];
            if (cmd.last_joint) begin
               duration_ff[cmd.leg] <= req_ff.move_ticks;
               elapsed_ff[cmd.leg]  <= '0;
            end
         end
         if (cmd.tick_wb) begin
            current_ff[idx] <= wb_pos;
            if (cmd.last_joint && (el_ff < dur_ff)) begin
               elapsed_ff[cmd.leg] <= DUR_W'(el_ff + 1'b1);
            end
         end
      end
   end

   // Request latch and arithmetic pipeline.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.tick_load) begin
         st_ff   <= start_ff[idx];
         dur_ff  <= duration_ff[cmd.leg];
         el_ff   <= elapsed_ff[cmd.leg];
         diff_ff <= (POS_W+1)'({target_ff[idx], {FRACTION_BITS{1'b0}}}) -
                    (POS_W+1)'(start_ff[idx]);
      end
      if (cmd.tick_mul) begin
         neg_ff <= diff_ff[POS_W];
         quo_ff <= DIVW'(abs_diff) * DIVW'(el_ff);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.rpl_rd) begin
         stage_ff[cmd.joint] <= current_ff[idx][POS_W-1:FRACTION_BITS];
      end
   end

   // Reply word, with missing joints reading as zero.
   always_comb begin
      leg_ext           = (LEG_W+REPLY_LEG_W)'(req_ff.frame_id[LEG_W-1:0]);
      rsp_in.reply_leg  = leg_ext[REPLY_LEG_W-1:0];
      rsp_in.pos_joint0 = stage_ff[0];
      rsp_in.pos_joint1 = (JOINTS_PER_LEG > 1) ? stage_ff[1] : '0;
      rsp_in.pos_joint2 = (JOINTS_PER_LEG > 2) ? stage_ff[2] : '0;
   end

   // Output register: holds a reply beat until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* hw/rtl/jli_ctrl.sv */
// Controller of the joint linear interpolator: sequences ticks, target
// writes and replies over the datapath. Depends on jli_pkg.
`default_nettype none
module jli_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  jli_pkg::status_type  status,
   output jli_pkg::cmd_type     cmd
);
   import jli_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_T_LOAD = 4'd2;
   localparam logic [3:0] S_T_MUL  = 4'd3;
   localparam logic [3:0] S_T_DIV  = 4'd4;
   localparam logic [3:0] S_T_WB   = 4'd5;
   localparam logic [3:0] S_SET    = 4'd6;
   localparam logic [3:0] S_RPL    = 4'd7;
   localparam logic [3:0] S_PUSH   = 4'd8;

   localparam logic [JOINT_W-1:0]   LAST_JOINT = JOINT_W'(JOINTS_PER_LEG - 1);
   localparam logic [LEG_W-1:0]     LAST_LEG   = LEG_W'(NUM_LEGS - 1);
   localparam logic [DIV_CNT_W-1:0] LAST_STEP  = DIV_CNT_W'(DIVW - 1);

   logic [3:0]           state_ff, state_in;
   logic [LEG_W-1:0]     leg_ff, leg_in;
   logic [JOINT_W-1:0]   joint_ff, joint_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 last_joint;

   assign last_joint = joint_ff == LAST_JOINT;

   // Next-state and command decode.
   always_comb begin
      state_in       = state_ff;
      leg_in         = leg_ff;
      joint_in       = joint_ff;
      cnt_in         = cnt_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.leg        = leg_ff;
      cmd.joint      = joint_ff;
      cmd.last_joint = last_joint;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            joint_in = '0;
            case (status.kind)
               KIND_TICK: begin
                  leg_in   = '0;
                  state_in = S_T_LOAD;
               end
               KIND_SET: begin
                  leg_in   = status.leg;
                  state_in = S_SET;
               end
               KIND_REPLY: begin
                  leg_in   = status.leg;
                  state_in = S_RPL;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_T_LOAD: begin
            cmd.tick_load = 1'b1;
            state_in      = S_T_MUL;
         end
         S_T_MUL: begin
            cmd.tick_mul = 1'b1;
            cnt_in       = '0;
            state_in     = S_T_DIV;
         end
         S_T_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = DIV_CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_STEP) begin
               state_in = S_T_WB;
            end
         end
         S_T_WB: begin
            cmd.tick_wb = 1'b1;
            state_in    = S_T_LOAD;
            if (last_joint) begin
               joint_in = '0;
               if (leg_ff == LAST_LEG) begin
                  state_in = S_IDLE;
               end else begin
                  leg_in = LEG_W'(leg_ff + 1'b1);
               end
            end else begin
               joint_in = JOINT_W'(joint_ff + 1'b1);
            end
         end
         S_SET: begin
            cmd.set_wr = 1'b1;
            if (last_joint) begin
               state_in = S_IDLE;
            end else begin
               joint_in = JOINT_W'(joint_ff + 1'b1);
            end
         end
         S_RPL: begin
            cmd.rpl_rd = 1'b1;
            if (last_joint) begin
               state_in = S_PUSH;
            end else begin
               joint_in = JOINT_W'(joint_ff + 1'b1);
            end
         end
         S_PUSH: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         leg_ff   <= '0;
         joint_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         leg_ff   <= leg_in;
         joint_ff <= joint_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTH
   // A reply is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !status.rsp_busy)
      else $error("reply loaded while output register busy");

   // Only one kind of state write happens in a cycle.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.tick_wb, cmd.set_wr, cmd.rpl_rd, cmd.rsp_load}))
      else $error("more than one state write in a cycle");

   // The divider runs its full count before write-back.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T_DIV && cnt_ff == LAST_STEP) |=> state_ff == S_T_WB)
      else $error("divider left early or late");

   // Write-back follows exactly the last division step.
   a_wb_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_wb |-> $past(cmd.div_step))
      else $error("write-back without finished division");
`endif

endmodule
`default_nettype wire

/* hw/rtl/joint_linear_interpolator.sv */
// Top level of the joint linear interpolator: joins the controller and the
// datapath. Depends on jli_pkg, jli_ctrl and jli_datapath.
//
// Simulates NUM_LEGS legs of JOINTS_PER_LEG servo joints. A request beat is
// either an interpolation tick or a received frame; a remote-request frame
// yields one reply beat with the integer position codes of that leg. One
// beat is taken at a time. A tick walks every joint through one shared
// multiplier and a one-bit-per-cycle divider, joint by joint. A target
// frame writes the joints of its leg one at a time, and a reply frame
// reads them likewise, then waits while an earlier reply beat still sits
// in the output register; other frames are dropped after decode.
`default_nettype none
module joint_linear_interpolator (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  jli_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output jli_pkg::rsp_type  rsp_data
);
   import jli_pkg::*;

   cmd_type    cmd;
   status_type status;

   jli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   jli_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for joint_linear_interpolator: drives ticks and frames, predicts
// the reply beats from a model of the legs, and checks them. Depends on jli_pkg.
`default_nettype none
module tb;
   import jli_pkg::*;

   localparam int REST_POS   = 7500 << FRACTION_BITS;
   localparam int CYCLE_LIMIT = 3_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle percentages of both sides and the long receiver hold-off.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_cycles = 0;

   // Leg state as the predictor sees it.
   logic [CODE_W-1:0] leg_target[NUM_LEGS][JOINTS_PER_LEG];
   logic [POS_W-1:0]  leg_start[NUM_LEGS][JOINTS_PER_LEG];
   logic [POS_W-1:0]  leg_pos[NUM_LEGS][JOINTS_PER_LEG];
   logic [DUR_W-1:0]  leg_dur[NUM_LEGS];
   logic [DUR_W-1:0]  leg_elapsed[NUM_LEGS];

   rsp_type pending_replies[$];
   int unsigned error_count = 0;
   int unsigned reply_count = 0;
   int unsigned beat_count = 0;
   int unsigned cycle_count = 0;

   joint_linear_interpolator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
      error_count++;
   endtask

   task automatic reset_legs();
      for (int l = 0; l < NUM_LEGS; l++) begin
         for (int j = 0; j < JOINTS_PER_LEG; j++) begin
            leg_target[l][j] = REST_CODE;
            leg_start[l][j] = POS_W'(REST_POS);
            leg_pos[l][j] = POS_W'(REST_POS);
         end
         leg_dur[l] = '0;
         leg_elapsed[l] = '0;
      end
   endtask

   // One tick moves every joint along its line toward the target.
   task automatic advance_legs();
      longint diff, q;
      for (int l = 0; l < NUM_LEGS; l++) begin
         for (int j = 0; j < JOINTS_PER_LEG; j++) begin
            if (leg_dur[l] == 0) begin
               leg_pos[l][j] = leg_start[l][j];
            end else begin
               diff = longint'({leg_target[l][j], {FRACTION_BITS{1'b0}}})
                      - longint'(leg_start[l][j]);
               q = (diff * longint'(leg_elapsed[l])) / longint'(leg_dur[l]);
               leg_pos[l][j] = POS_W'(longint'(leg_start[l][j]) + q);
            end
         end
         if (leg_elapsed[l] < leg_dur[l]) leg_elapsed[l] = DUR_W'(leg_elapsed[l] + 1'b1);
      end
   endtask

   // Apply one accepted beat to the leg model and queue any reply.
   task automatic predict_beat(input req_type r);
      rsp_type e;
      logic [15:0] codes[3];
      int l;
      if (r.action == 1'b0) begin
         advance_legs();
         return;
      end
      if (!r.is_channel_a || r.frame_id >= NUM_LEGS || r.command != CMD_SET) return;
      l = r.frame_id;
      codes[0] = r.code_joint0;
      codes[1] = r.code_joint1;
      codes[2] = r.code_joint2;
      if (!r.remote_request) begin
         for (int j = 0; j < JOINTS_PER_LEG; j++) begin
            leg_target[l][j] = codes[j];
            leg_start[l][j] = leg_pos[l][j];
         end
         leg_dur[l] = r.move_ticks;
         leg_elapsed[l] = '0;
         return;
      end
      e = '0;
      e.reply_leg = 3'(l);
      e.pos_joint0 = leg_pos[l][0][POS_W-1 -: CODE_W];
      if (JOINTS_PER_LEG > 1) e.pos_joint1 = leg_pos[l][1][POS_W-1 -: CODE_W];
      if (JOINTS_PER_LEG > 2) e.pos_joint2 = leg_pos[l][2][POS_W-1 -: CODE_W];
      pending_replies.push_back(e);
   endtask

   // Send one beat, holding valid until it is accepted. Valid drops only
   // while the sender idles, so back-to-back beats keep it high.
   task automatic send_beat(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_beat(r);
      beat_count++;
   endtask

   // Receiver readiness: random stalls, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted reply beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply leg", rsp_data.reply_leg, -1);
         end else begin
            e = pending_replies.pop_front();
            reply_count++;
            if (rsp_data.reply_leg !== e.reply_leg)
               report_mismatch("reply_leg", rsp_data.reply_leg, e.reply_leg);
            if (rsp_data.pos_joint0 !== e.pos_joint0)
               report_mismatch("pos_joint0", rsp_data.pos_joint0, e.pos_joint0);
            if (rsp_data.pos_joint1 !== e.pos_joint1)
               report_mismatch("pos_joint1", rsp_data.pos_joint1, e.pos_joint1);
            if (rsp_data.pos_joint2 !== e.pos_joint2)
               report_mismatch("pos_joint2", rsp_data.pos_joint2, e.pos_joint2);
         end
      end
   end

   function automatic req_type make_frame(input int leg, input bit remote,
                                          input int c0, input int c1, input int c2,
                                          input int ticks);
      req_type r;
      r = '0;
      r.action = 1'b1;
      r.is_channel_a = 1'b1;
      r.frame_id = 11'(leg);
      r.command = CMD_SET;
      r.remote_request = remote;
      r.code_joint0 = 16'(c0);
      r.code_joint1 = 16'(c1);
      r.code_joint2 = 16'(c2);
      r.move_ticks = 8'(ticks);
      return r;
   endfunction

   function automatic req_type make_tick();
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom}));
      r.action = 1'b0;
      return r;
   endfunction

   // Drop valid, then wait until every expected reply has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Extremes of codes and durations, zero duration, ignored frames,
   // reply before tick, and a tick with junk in the other fields.
   task automatic test_directed();
      req_type r;
      send_beat(make_frame(0, 1, 0, 0, 0, 0));
      send_beat(make_frame(0, 0, 65535, 0, 12345, 4));
      send_beat(make_frame(0, 1, 0, 0, 0, 0));
      for (int i = 0; i < 5; i++) send_beat(make_tick());
      send_beat(make_frame(0, 1, 0, 0, 0, 0));
      send_beat(make_frame(5, 0, 0, 65535, 1, 255));
      send_beat(make_frame(1, 0, 100, 200, 300, 0));
      send_beat(make_tick());
      send_beat(make_frame(5, 1, 0, 0, 0, 0));
      send_beat(make_frame(1, 1, 0, 0, 0, 0));
      r = make_frame(2, 0, 1, 1, 1, 1); r.is_channel_a = 1'b0; send_beat(r);
      r = make_frame(2, 0, 1, 1, 1, 1); r.command = 8'hFF; send_beat(r);
      r = make_frame(2, 0, 1, 1, 1, 1); r.command = 8'd0; send_beat(r);
      r = make_frame(0, 1, 0, 0, 0, 0); r.frame_id = 11'd2047; send_beat(r);
      r = make_frame(0, 1, 0, 0, 0, 0); r.frame_id = 11'd6; send_beat(r);
      send_beat(make_frame(2, 1, 0, 0, 0, 0));
      send_beat(make_frame(0, 1, 0, 0, 0, 0));
      wait_drained();
   endtask

   // Mostly valid set and reply frames with ticks between; some noise.
   task automatic test_random(input int count);
      req_type r;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            r = make_tick();
         end else if (pick < 60) begin
            r = make_frame($urandom_range(NUM_LEGS - 1), 0, $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535),
                           ($urandom_range(3) == 0) ? $urandom_range(255)
                                                    : $urandom_range(6));
         end else if (pick < 90) begin
            r = make_frame($urandom_range(NUM_LEGS - 1), 1, $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(255));
         end else begin
            r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom}));
            r.action = 1'b1;
            if ($urandom_range(1)) r.frame_id = 11'($urandom_range(NUM_LEGS - 1));
         end
         send_beat(r);
      end
   endtask

   // Receiver holds off while replies pile up, then the sender waits for all.
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) send_beat(make_frame(i % NUM_LEGS, 1, 0, 0, 0, 0));
      wait_drained();
   endtask

   initial begin
      reset_legs();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(250);
      send_idle_pct = 49; recv_stall_pct = 0;  test_random(250);
      send_idle_pct = 0;  recv_stall_pct = 49; test_random(250);
      test_backpressure();
      send_idle_pct = 25; recv_stall_pct = 25; test_random(250);
      wait_drained();
      repeat (700) @(posedge clock);
      $display("covered %0d request beats and %0d reply beats over four idling mixes",
               beat_count, reply_count);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d replies missing", error_count, pending_replies.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/jli_pkg.sv
hw/rtl/jli_datapath.sv
hw/rtl/jli_ctrl.sv
hw/rtl/joint_linear_interpolator.sv
dv/tb.sv
